[design/slfp_pkg.sv]
// slfp_pkg: shared types and constants for the STX/length/checksum frame parser.
// No dependencies; used by every module of the parser.
package slfp_pkg;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE   = 8'h03;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_LENGTH   = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_CHECKSUM = 3'd3,
    PH_END      = 3'd4,
    PH_DONE     = 3'd5,
    PH_ERROR    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_START    = 2'd1,
    ERR_CHECKSUM = 2'd2,
    ERR_END      = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } beat_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_ok;
    logic [1:0] error_kind;
  } beat_out_t;

endpackage

[design/slfp_step.sv]
// slfp_step: frame parser state registers and the per-beat decode logic.
// Depends on slfp_pkg.
module slfp_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  slfp_pkg::beat_in_t  beat_in,
  output slfp_pkg::beat_out_t beat_out
);

  slfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= slfp_pkg::PH_START;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      sum_r   <= 8'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign cnt_inc = cnt_r + 8'd1;

  always_comb begin
    slfp_pkg::err_t err;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    err       = slfp_pkg::ERR_NONE;
    beat_out  = '0;
    if (beat_in.restart) begin
      phase_nxt = slfp_pkg::PH_START;
      len_nxt   = 8'd0;
      cnt_nxt   = 8'd0;
      sum_nxt   = 8'd0;
    end else begin
      unique case (phase_r)
        slfp_pkg::PH_START: begin
          if (beat_in.rx_byte == slfp_pkg::START_BYTE) begin
            sum_nxt   = 8'd0;
            cnt_nxt   = 8'd0;
            phase_nxt = slfp_pkg::PH_LENGTH;
          end else begin
            phase_nxt = slfp_pkg::PH_ERROR;
            err       = slfp_pkg::ERR_START;
          end
        end
        slfp_pkg::PH_LENGTH: begin
          len_nxt   = beat_in.rx_byte;
          sum_nxt   = beat_in.rx_byte;
          cnt_nxt   = 8'd0;
          phase_nxt = (beat_in.rx_byte == 8'd0) ? slfp_pkg::PH_CHECKSUM
                                                : slfp_pkg::PH_PAYLOAD;
        end
        slfp_pkg::PH_PAYLOAD: begin
          beat_out.payload_valid = 1'b1;
          beat_out.payload_byte  = beat_in.rx_byte;
          beat_out.payload_index = cnt_r;
          cnt_nxt = cnt_inc;
          sum_nxt = sum_r + beat_in.rx_byte;
          if (cnt_inc >= len_r) phase_nxt = slfp_pkg::PH_CHECKSUM;
        end
        slfp_pkg::PH_CHECKSUM: begin
          if (beat_in.rx_byte == sum_r) begin
            phase_nxt = slfp_pkg::PH_END;
          end else begin
            phase_nxt = slfp_pkg::PH_ERROR;
            err       = slfp_pkg::ERR_CHECKSUM;
          end
        end
        slfp_pkg::PH_END: begin
          if (beat_in.rx_byte == slfp_pkg::END_BYTE) begin
            phase_nxt         = slfp_pkg::PH_DONE;
            beat_out.frame_ok = 1'b1;
          end else begin
            phase_nxt = slfp_pkg::PH_ERROR;
            err       = slfp_pkg::ERR_END;
          end
        end
        slfp_pkg::PH_DONE: begin
          phase_nxt = slfp_pkg::PH_DONE;
        end
        default: begin
          phase_nxt = slfp_pkg::PH_ERROR;
        end
      endcase
    end
    beat_out.status     = phase_nxt;
    beat_out.error_kind = err;
  end

endmodule

[design/stx_length_checksum_frame_parser_core.sv]
// Top level of the STX/length/checksum frame parser: input register, decode, result register.
// Depends on slfp_pkg and slfp_step.
//
//   channel | direction | handshake          | fields
//   in_     | in        | in_valid/in_stall   | rx_byte[7:0], restart
//   out_    | out       | out_valid/out_stall | status, payload_*, frame_ok, error_kind
//
// One beat per cycle while out_ is not stalled; a beat passes the input register, then the result register.
// Parser state advances as a beat moves from the input register into the result register.
// Synchronous active-low reset clears the parser state and both valid flags.
// A stall on out_ holds the result register and, once the input register is full, in_stall.
module stx_length_checksum_frame_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic       out_payload_valid,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_payload_index,
  output logic       out_frame_ok,
  output logic [1:0] out_error_kind
);

  logic                s1_valid_r;
  slfp_pkg::beat_in_t  s1_beat_r;
  logic                s2_valid_r;
  slfp_pkg::beat_out_t s2_beat_r;
  slfp_pkg::beat_out_t step_out;
  logic                s2_load_ok;
  logic                s1_load_ok;
  logic                step_en;

  assign s2_load_ok = !s2_valid_r || !out_stall;
  assign s1_load_ok = !s1_valid_r || s2_load_ok;
  assign step_en    = s1_valid_r && s2_load_ok;
  assign in_stall   = !s1_load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load_ok) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load_ok && in_valid) begin
      s1_beat_r.rx_byte <= in_rx_byte;
      s1_beat_r.restart <= in_restart;
    end
  end

  slfp_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .beat_in  (s1_beat_r),
    .beat_out (step_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load_ok) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) s2_beat_r <= step_out;
  end

  assign out_valid         = s2_valid_r;
  assign out_status        = s2_beat_r.status;
  assign out_payload_valid = s2_beat_r.payload_valid;
  assign out_payload_byte  = s2_beat_r.payload_byte;
  assign out_payload_index = s2_beat_r.payload_index;
  assign out_frame_ok      = s2_beat_r.frame_ok;
  assign out_error_kind    = s2_beat_r.error_kind;

endmodule

[design/slfp_checker.sv]
// slfp_checker: port-level checks on result beats of the frame parser, bound to the top level.
// Depends on slfp_pkg and stx_length_checksum_frame_parser_core.
module slfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic       out_payload_valid,
  input logic [7:0] out_payload_byte,
  input logic [7:0] out_payload_index,
  input logic       out_frame_ok,
  input logic [1:0] out_error_kind
);

  a_idle_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_payload_valid) |-> (out_payload_byte == 8'd0 && out_payload_index == 8'd0))
    else $error("payload fields nonzero without payload_valid");

  a_ok_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_ok) |->
      (out_status == slfp_pkg::PH_DONE && out_error_kind == slfp_pkg::ERR_NONE))
    else $error("frame_ok without done status");

  a_err_is_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_kind != slfp_pkg::ERR_NONE) |-> (out_status == slfp_pkg::PH_ERROR))
    else $error("error_kind set without error status");

  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload_valid) |->
      (out_status == slfp_pkg::PH_PAYLOAD || out_status == slfp_pkg::PH_CHECKSUM))
    else $error("payload beat with wrong status");

endmodule

bind stx_length_checksum_frame_parser_core slfp_checker u_slfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_payload_valid (out_payload_valid),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index),
  .out_frame_ok      (out_frame_ok),
  .out_error_kind    (out_error_kind)
);

[dv/slfp_frame_checker.sv]
// slfp_frame_checker: watches the in_ and out_ channels of the frame parser,
// predicts each result beat from the accepted input beats and compares field by field.
// Depends on slfp_pkg.
module slfp_frame_checker
  import slfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_restart,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_status,
  input  logic       out_payload_valid,
  input  logic [7:0] out_payload_byte,
  input  logic [7:0] out_payload_index,
  input  logic       out_frame_ok,
  input  logic [1:0] out_error_kind,
  output int         mismatches,
  output int         pending,
  output int         results_seen,
  output int         good_frames,
  output int         bad_frames
);

  phase_t     cur_phase;
  logic [7:0] frame_len;
  logic [7:0] byte_cnt;
  logic [7:0] frame_sum;
  beat_out_t  expected_q[$];

  function automatic beat_out_t parse_byte(input logic [7:0] b, input logic rs);
    beat_out_t r;
    r = '0;
    if (rs) begin
      cur_phase = PH_START;
      frame_len = '0;
      byte_cnt  = '0;
      frame_sum = '0;
    end else begin
      case (cur_phase)
        PH_START: begin
          if (b == START_BYTE) begin
            frame_sum = '0;
            byte_cnt  = '0;
            cur_phase = PH_LENGTH;
          end else begin
            cur_phase    = PH_ERROR;
            r.error_kind = ERR_START;
          end
        end
        PH_LENGTH: begin
          frame_len = b;
          frame_sum = b;
          byte_cnt  = '0;
          cur_phase = (b == 8'd0) ? PH_CHECKSUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          r.payload_index = byte_cnt;
          byte_cnt  = byte_cnt + 8'd1;
          frame_sum = frame_sum + b;
          if (byte_cnt >= frame_len) cur_phase = PH_CHECKSUM;
        end
        PH_CHECKSUM: begin
          if (b == frame_sum) begin
            cur_phase = PH_END;
          end else begin
            cur_phase    = PH_ERROR;
            r.error_kind = ERR_CHECKSUM;
          end
        end
        PH_END: begin
          if (b == END_BYTE) begin
            cur_phase  = PH_DONE;
            r.frame_ok = 1'b1;
          end else begin
            cur_phase    = PH_ERROR;
            r.error_kind = ERR_END;
          end
        end
        PH_DONE: ;
        default: cur_phase = PH_ERROR;
      endcase
    end
    r.status = cur_phase;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    beat_out_t want;
    if (!rst_n) begin
      cur_phase = PH_START;
      frame_len = '0;
      byte_cnt  = '0;
      frame_sum = '0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("out_ beat with no expected result (status %0d)", out_status);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 8'(want.status), 8'(out_status));
          check_field("payload_valid", 8'(want.payload_valid), 8'(out_payload_valid));
          check_field("payload_byte", want.payload_byte, out_payload_byte);
          check_field("payload_index", want.payload_index, out_payload_index);
          check_field("frame_ok", 8'(want.frame_ok), 8'(out_frame_ok));
          check_field("error_kind", 8'(want.error_kind), 8'(out_error_kind));
        end
        if (out_frame_ok === 1'b1) good_frames++;
        if (out_error_kind != ERR_NONE) bad_frames++;
      end
      if (in_valid && !in_stall) expected_q.push_back(parse_byte(in_rx_byte, in_restart));
    end
    pending = expected_q.size();
  end

endmodule

[dv/tb.sv]
// tb: drives directed and random byte streams (frames, flawed frames, noise) into the
// frame parser under several idle/stall mixes and reports the verdict.
// Depends on slfp_pkg, slfp_frame_checker and stx_length_checksum_frame_parser_core.
module tb;
  import slfp_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int TIMEOUT_CYCLES = 200_000;
  localparam int BEATS_PER_MIX = 35;

  typedef enum int {FRAME_CLEAN, FRAME_BAD_SUM, FRAME_BAD_END, FRAME_CUT} frame_flaw_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = '0;
  logic       in_restart = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_status;
  logic       out_payload_valid;
  logic [7:0] out_payload_byte;
  logic [7:0] out_payload_index;
  logic       out_frame_ok;
  logic [1:0] out_error_kind;

  int mismatches;
  int pending;
  int results_seen;
  int good_frames;
  int bad_frames;
  int beats_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  stx_length_checksum_frame_parser_core u_dut (.*);

  slfp_frame_checker u_checker (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // called and returns at a falling edge
  task automatic send_beat(input logic [7:0] b, input logic rs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    in_restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int len, input frame_flaw_t flaw);
    logic [7:0] frame_q[$];
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] tail;
    int         cut;
    frame_q.push_back(START_BYTE);
    frame_q.push_back(8'(len));
    sum = 8'(len);
    repeat (len) begin
      b = 8'($urandom);
      frame_q.push_back(b);
      sum += b;
    end
    if (flaw == FRAME_BAD_SUM) sum ^= 8'd1 << $urandom_range(7);
    frame_q.push_back(sum);
    tail = END_BYTE;
    if (flaw == FRAME_BAD_END) begin
      tail = 8'($urandom);
      if (tail == END_BYTE) tail = 8'hFF;
    end
    frame_q.push_back(tail);
    cut = (flaw == FRAME_CUT) ? $urandom_range(frame_q.size() - 1, 1) : frame_q.size();
    for (int i = 0; i < cut; i++) send_beat(frame_q[i], 1'b0);
    // trailing bytes land in done/error and are ignored there; after a cut frame they continue it
    repeat ($urandom_range(2)) send_beat(8'($urandom), 1'b0);
    send_beat(8'($urandom), 1'b1);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 1)) send_beat(8'($urandom), ($urandom_range(7) == 0));
    send_beat(8'($urandom), 1'b1);
  endtask

  task automatic send_random_sequence();
    int pick;
    int len;
    pick = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
    if (pick < 60)      send_frame(len, FRAME_CLEAN);
    else if (pick < 70) send_frame(len, FRAME_BAD_SUM);
    else if (pick < 78) send_frame(len, FRAME_BAD_END);
    else if (pick < 88) send_frame(len, FRAME_CUT);
    else                send_noise();
  endtask

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $error("timeout with %0d results outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int target;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // bad start, byte ignored in error, restart
    send_beat(8'hFF, 1'b0);
    send_beat(START_BYTE, 1'b0);
    send_beat(8'hA5, 1'b1);
    // empty frame
    send_beat(START_BYTE, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(END_BYTE, 1'b0);
    send_beat(8'h00, 1'b1);
    // two payload bytes, checksum wraps
    send_beat(START_BYTE, 1'b0);
    send_beat(8'h02, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h81, 1'b0);
    send_beat(END_BYTE, 1'b0);
    send_beat(8'h5A, 1'b1);
    // bad checksum
    send_beat(START_BYTE, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h05, 1'b0);
    send_beat(8'h07, 1'b0);
    send_beat(8'h00, 1'b1);
    // bad end
    send_beat(START_BYTE, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h05, 1'b0);
    send_beat(8'h06, 1'b0);
    send_beat(8'h04, 1'b0);
    send_beat(8'hFF, 1'b1);

    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      if (mix == 0) send_frame(255, FRAME_CLEAN);
      target = beats_sent + BEATS_PER_MIX;
      while (beats_sent < target) send_random_sequence();
    end

    in_valid  <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Summary: %0d beats driven, %0d results checked under four idle/stall mixes,",
             beats_sent, results_seen);
    $display("         %0d frames accepted, %0d ended in an error (one 255-byte payload)",
             good_frames, bad_frames);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
